// ----- rtl/lpbt_pkg.sv -----
package lpbt_pkg;

	localparam int ENTRIES     = 16;
	localparam int IDX_BITS    = $clog2(ENTRIES);
	localparam int CNT_BITS    = IDX_BITS + 1;
	localparam int KEY_BITS    = 16;
	localparam int HANDLE_BITS = 32;
	localparam int STAMP_BITS  = 32;
	localparam int CAP_BITS    = 5;
	localparam logic [CAP_BITS-1:0] CAP_RESET = CAP_BITS'(16);

	typedef enum logic [1:0] {
		OP_FIND   = 2'd0,
		OP_ADD    = 2'd1,
		OP_REMOVE = 2'd2,
		OP_NOP    = 2'd3
	} opcode_t;

	typedef struct packed {
		opcode_t                opcode;
		logic [KEY_BITS-1:0]    table_id;
		logic [HANDLE_BITS-1:0] page_handle;
	} in_t;

	typedef struct packed {
		logic                   hit;
		logic [HANDLE_BITS-1:0] page_out;
		logic                   evicted;
		logic [KEY_BITS-1:0]    evicted_table_id;
		logic [HANDLE_BITS-1:0] evicted_page;
	} out_t;

	// controller -> datapath
	typedef struct packed {
		logic accept;
		logic scan_step;
		logic fetch;
		logic commit;
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic no_scan;
		logic lookup;
		logic is_remove;
		logic key_match;
		logic scan_last;
		logic out_free;
	} status_t;

endpackage

// ----- rtl/lpbt_ctrl.sv -----
module lpbt_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_stall,
	input  lpbt_pkg::status_t sts,
	output lpbt_pkg::cmd_t   cmd
);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_FETCH  = 4'b0100,
		S_COMMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d       = state_q;
		cmd           = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.no_scan) begin
					state_d = S_COMMIT;
				end else begin
					cmd.scan_step = 1'b1;
					if (sts.lookup && sts.key_match) begin
						state_d = sts.is_remove ? S_FETCH : S_COMMIT;
					end else if (sts.scan_last) begin
						state_d = S_COMMIT;
					end
				end
			end
			S_FETCH: begin
				cmd.fetch = 1'b1;
				state_d   = S_COMMIT;
			end
			S_COMMIT: begin
				if (sts.out_free) begin
					cmd.commit = 1'b1;
					state_d    = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ----- rtl/lpbt_dpath.sv -----
module lpbt_dpath (
	input  logic                          clk,
	input  logic                          arst_n,
	input  lpbt_pkg::in_t                 in_data,
	input  logic                          cfg_we,
	input  logic [lpbt_pkg::CAP_BITS-1:0] cfg_data,
	input  logic                          out_stall,
	output logic                          out_valid,
	output lpbt_pkg::out_t                out_data,
	input  lpbt_pkg::cmd_t                cmd,
	output lpbt_pkg::status_t             sts
);

	// slot store
	logic [lpbt_pkg::KEY_BITS-1:0]    keys_q   [lpbt_pkg::ENTRIES];
	logic [lpbt_pkg::HANDLE_BITS-1:0] pages_q  [lpbt_pkg::ENTRIES];
	logic [lpbt_pkg::STAMP_BITS-1:0]  stamps_q [lpbt_pkg::ENTRIES];

	// latched item
	lpbt_pkg::opcode_t                op_q;
	logic [lpbt_pkg::KEY_BITS-1:0]    key_q;
	logic [lpbt_pkg::HANDLE_BITS-1:0] page_q;

	logic [lpbt_pkg::CAP_BITS-1:0]    cap_q;
	logic [lpbt_pkg::CNT_BITS-1:0]    fill_q;
	logic [lpbt_pkg::STAMP_BITS-1:0]  clock_q;
	logic [lpbt_pkg::IDX_BITS-1:0]    idx_q;

	// scan results
	logic                             found_q;
	logic [lpbt_pkg::IDX_BITS-1:0]    found_idx_q;
	logic [lpbt_pkg::HANDLE_BITS-1:0] found_page_q;
	logic [lpbt_pkg::IDX_BITS-1:0]    victim_idx_q;
	logic [lpbt_pkg::STAMP_BITS-1:0]  least_q;
	logic [lpbt_pkg::KEY_BITS-1:0]    victim_key_q;
	logic [lpbt_pkg::HANDLE_BITS-1:0] victim_page_q;
	logic [lpbt_pkg::KEY_BITS-1:0]    mv_key_q;
	logic [lpbt_pkg::HANDLE_BITS-1:0] mv_page_q;

	logic                             out_valid_q;
	lpbt_pkg::out_t                   out_q;

	logic [lpbt_pkg::CNT_BITS-1:0]    cap_eff;
	logic [lpbt_pkg::CNT_BITS-1:0]    fill_m1;
	logic [lpbt_pkg::IDX_BITS-1:0]    last_idx;
	logic [lpbt_pkg::IDX_BITS-1:0]    rd_idx;
	logic [lpbt_pkg::KEY_BITS-1:0]    rd_key;
	logic [lpbt_pkg::HANDLE_BITS-1:0] rd_page;
	logic [lpbt_pkg::STAMP_BITS-1:0]  rd_stamp;
	logic                             evict_needed;
	logic                             lookup;
	logic                             new_least;
	lpbt_pkg::out_t                   res;

	// out-of-range capacity clamps to 1..ENTRIES
	always_comb begin
		if (cap_q == '0) begin
			cap_eff = lpbt_pkg::CNT_BITS'(1);
		end else if (int'(cap_q) > lpbt_pkg::ENTRIES) begin
			cap_eff = lpbt_pkg::CNT_BITS'(lpbt_pkg::ENTRIES);
		end else begin
			cap_eff = lpbt_pkg::CNT_BITS'(cap_q);
		end
	end

	assign evict_needed = (fill_q >= cap_eff);
	assign fill_m1      = fill_q - lpbt_pkg::CNT_BITS'(1);
	assign last_idx     = fill_m1[lpbt_pkg::IDX_BITS-1:0];
	assign lookup       = (op_q == lpbt_pkg::OP_FIND) || (op_q == lpbt_pkg::OP_REMOVE);

	// single read port: scan pointer, or last slot while fetching the mover
	assign rd_idx   = cmd.fetch ? last_idx : idx_q;
	assign rd_key   = keys_q[rd_idx];
	assign rd_page  = pages_q[rd_idx];
	assign rd_stamp = stamps_q[rd_idx];

	assign new_least = (idx_q == '0) || (rd_stamp < least_q);

	always_comb begin
		sts           = '0;
		sts.no_scan   = (op_q == lpbt_pkg::OP_NOP) || (fill_q == '0) ||
		                ((op_q == lpbt_pkg::OP_ADD) && !evict_needed);
		sts.lookup    = lookup;
		sts.is_remove = (op_q == lpbt_pkg::OP_REMOVE);
		sts.key_match = (rd_key == key_q);
		sts.scan_last = ({1'b0, idx_q} == fill_m1);
		sts.out_free  = !out_valid_q || !out_stall;
	end

	// result of the item being committed
	always_comb begin
		res = '0;
		case (op_q) inside
			lpbt_pkg::OP_FIND, lpbt_pkg::OP_REMOVE: begin
				if (found_q) begin
					res.hit      = 1'b1;
					res.page_out = found_page_q;
				end
			end
			lpbt_pkg::OP_ADD: begin
				if (evict_needed) begin
					res.evicted          = 1'b1;
					res.evicted_table_id = victim_key_q;
					res.evicted_page     = victim_page_q;
				end
			end
			default: begin
				res = '0;
			end
		endcase
	end

	// slot store writes
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			case (op_q)
				lpbt_pkg::OP_FIND: begin
					if (found_q) begin
						stamps_q[found_idx_q] <= clock_q;
					end
				end
				lpbt_pkg::OP_ADD: begin
					if (evict_needed) begin
						keys_q[victim_idx_q]   <= key_q;
						pages_q[victim_idx_q]  <= page_q;
						stamps_q[victim_idx_q] <= clock_q;
					end else if (fill_q < lpbt_pkg::CNT_BITS'(lpbt_pkg::ENTRIES)) begin
						keys_q[fill_q[lpbt_pkg::IDX_BITS-1:0]]   <= key_q;
						pages_q[fill_q[lpbt_pkg::IDX_BITS-1:0]]  <= page_q;
						stamps_q[fill_q[lpbt_pkg::IDX_BITS-1:0]] <= clock_q;
					end
				end
				lpbt_pkg::OP_REMOVE: begin
					if (found_q) begin
						keys_q[found_idx_q]   <= mv_key_q;
						pages_q[found_idx_q]  <= mv_page_q;
						stamps_q[found_idx_q] <= clock_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// item, scan and result payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q   <= in_data.opcode;
			key_q  <= in_data.table_id;
			page_q <= in_data.page_handle;
		end
		if (cmd.scan_step) begin
			if (lookup && sts.key_match) begin
				found_idx_q  <= idx_q;
				found_page_q <= rd_page;
			end
			if (new_least) begin
				least_q       <= rd_stamp;
				victim_idx_q  <= idx_q;
				victim_key_q  <= rd_key;
				victim_page_q <= rd_page;
			end
		end
		if (cmd.fetch) begin
			mv_key_q  <= rd_key;
			mv_page_q <= rd_page;
		end
		if (cmd.commit) begin
			out_q <= res;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q       <= lpbt_pkg::CAP_RESET;
			fill_q      <= '0;
			clock_q     <= lpbt_pkg::STAMP_BITS'(1);
			idx_q       <= '0;
			found_q     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_data;
			end
			if (cmd.accept) begin
				idx_q   <= '0;
				found_q <= 1'b0;
				if (in_data.opcode != lpbt_pkg::OP_NOP) begin
					clock_q <= clock_q + lpbt_pkg::STAMP_BITS'(1);
				end
			end
			if (cmd.scan_step) begin
				idx_q <= idx_q + lpbt_pkg::IDX_BITS'(1);
				if (lookup && sts.key_match) begin
					found_q <= 1'b1;
				end
			end
			if (cmd.commit) begin
				if ((op_q == lpbt_pkg::OP_ADD) && !evict_needed &&
				    (fill_q < lpbt_pkg::CNT_BITS'(lpbt_pkg::ENTRIES))) begin
					fill_q <= fill_q + lpbt_pkg::CNT_BITS'(1);
				end else if ((op_q == lpbt_pkg::OP_REMOVE) && found_q) begin
					fill_q <= fill_m1;
				end
			end
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// ----- rtl/lru_page_buffer_table_unit.sv -----
// LRU page buffer table: a sixteen-slot fully associative store of page
// handles keyed by table id, with least-recently-used replacement by use
// stamps. Each beat on the input carries an opcode (find, add, remove; the
// fourth code does nothing) and gives exactly one result beat. Every real
// operation advances a 32-bit use clock first. Find restamps a hit; add
// appends, or, once the fill reaches capacity_in_use (0 acts as 1, above 16
// acts as 16), replaces the slot with the least stamp (first in slot order
// on a tie) and reports the old entry for write-back; remove returns the
// handle and moves the last filled entry into the freed slot. Timing: one
// item at a time. The scan walks the filled slots one per cycle through the
// single read port of the slot store, stopping at the first match for find
// and remove and covering all filled slots for an evicting add. The result
// is registered on commit, in the commit state that follows the scan state
// (which scans nothing for a no-op, an empty buffer or an add below
// capacity); a remove hit passes through a fetch state first to read the
// last entry. Input is taken again the cycle after the result is
// registered. The result sits in an output register, so a new item is
// taken while it waits; the block only holds off when a second result is
// ready and the first is still stalled. capacity_in_use is written over
// the configuration channel, which is always ready and must be used only
// while the block is idle. No clearing pass after reset: slots are never
// read above the fill count.
module lru_page_buffer_table_unit (
	input  logic                          clk,
	input  logic                          arst_n,
	// item channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  lpbt_pkg::in_t                 in_data,
	// result channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output lpbt_pkg::out_t                out_data,
	// capacity register write
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [lpbt_pkg::CAP_BITS-1:0] cfg_data
);

	lpbt_pkg::cmd_t    cmd;
	lpbt_pkg::status_t sts;

	// register write is a single flop load, never back-pressured
	assign cfg_ready = 1'b1;

	lpbt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	lpbt_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_data   (in_data),
		.cfg_we    (cfg_valid),
		.cfg_data  (cfg_data),
		.out_stall (out_stall),
		.out_valid (out_valid),
		.out_data  (out_data),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule

// ----- rtl/lpbt_checks.sv -----
module lpbt_checks (
	input logic           clk,
	input logic           arst_n,
	input logic           in_valid,
	input logic           in_stall,
	input logic           out_valid,
	input logic           out_stall,
	input lpbt_pkg::out_t out_data
);

	// a stalled result beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("result beat changed while stalled");

	// one item at a time: accepting a beat closes the input next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input open straight after accept");

	// a result is either a lookup hit or an eviction, never both
	a_hit_xor_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.hit && out_data.evicted))
		else $error("hit and eviction in one result");

	// fields of an inapplicable case read zero
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.hit || (out_data.page_out == '0)) &&
		(out_data.evicted || ((out_data.evicted_table_id == '0) &&
		(out_data.evicted_page == '0))))
		else $error("unused result fields not zero");

endmodule

bind lru_page_buffer_table_unit lpbt_checks u_lpbt_checks (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);
